@@ rtl/core/tiag_pkg.sv @@
`default_nettype none
package tiag_pkg;

    // Fixed field widths
    localparam int K_W       = 13;  // block length / address
    localparam int P_W       = 9;   // prime, column and residue values
    localparam int G_W       = 5;   // primitive root
    localparam int ROW_W     = 5;   // row count / row number
    localparam int CNT_W     = 14;  // matrix position count (R*C)
    localparam int TBL_IDX_W = 7;
    localparam int TBL_SIZE  = 77;

    // Defaults for the top-level parameters
    localparam int MAX_ROWS_DEF      = 20;
    localparam int MAX_LENGTH_DEF    = 5120;
    localparam int PRIME_ENTRIES_DEF = 76;

    localparam logic [K_W-1:0] LEN_MIN     = 13'd40;
    localparam logic [K_W-1:0] RESET_LEN   = 13'd40;
    localparam logic [K_W-1:0] R5_BELOW    = 13'd160;
    localparam logic [K_W-1:0] R10_MAX     = 13'd200;
    localparam logic [K_W-1:0] SPEC_LO     = 13'd481;
    localparam logic [K_W-1:0] SPEC_HI     = 13'd530;
    localparam logic [K_W-1:0] PATB_LO1    = 13'd2281;
    localparam logic [K_W-1:0] PATB_HI1    = 13'd2480;
    localparam logic [K_W-1:0] PATB_LO2    = 13'd3161;
    localparam logic [K_W-1:0] PATB_HI2    = 13'd3210;

    localparam logic [ROW_W-1:0] ROWS_5  = 5'd5;
    localparam logic [ROW_W-1:0] ROWS_10 = 5'd10;
    localparam logic [ROW_W-1:0] ROWS_20 = 5'd20;

    localparam logic [P_W-1:0]       SPEC_PRIME = 9'd53;
    localparam logic [TBL_IDX_W-1:0] SPEC_PIDX  = 7'd12;

    typedef enum logic [1:0] {
        PAT_A  = 2'd0,
        PAT_B  = 2'd1,
        PAT_10 = 2'd2,
        PAT_5  = 2'd3
    } t_pattern;

    localparam logic [ROW_W-1:0] PAT_A_ROWS [0:19] = '{
        5'd19, 5'd9, 5'd14, 5'd4, 5'd0, 5'd2, 5'd5, 5'd7, 5'd12, 5'd18,
        5'd10, 5'd8, 5'd13, 5'd17, 5'd3, 5'd1, 5'd16, 5'd6, 5'd15, 5'd11};
    localparam logic [ROW_W-1:0] PAT_B_ROWS [0:19] = '{
        5'd19, 5'd9, 5'd14, 5'd4, 5'd0, 5'd2, 5'd5, 5'd7, 5'd12, 5'd18,
        5'd16, 5'd13, 5'd17, 5'd15, 5'd3, 5'd1, 5'd6, 5'd11, 5'd8, 5'd10};

    localparam logic [P_W-1:0] PRIMES [0:TBL_SIZE-1] = '{
        9'd7, 9'd11, 9'd13, 9'd17, 9'd19, 9'd23, 9'd29, 9'd31, 9'd37, 9'd41,
        9'd43, 9'd47, 9'd53, 9'd59, 9'd61, 9'd67, 9'd71, 9'd73, 9'd79, 9'd83,
        9'd89, 9'd97, 9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131, 9'd137,
        9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173, 9'd179, 9'd181, 9'd191,
        9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227, 9'd229, 9'd233, 9'd239, 9'd241,
        9'd251, 9'd257, 9'd263, 9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307,
        9'd311, 9'd313, 9'd317, 9'd331, 9'd337, 9'd347, 9'd349, 9'd353, 9'd359, 9'd367,
        9'd373, 9'd379, 9'd383, 9'd389, 9'd397, 9'd401, 9'd409};

    localparam logic [G_W-1:0] PROOTS [0:TBL_SIZE-1] = '{
        5'd3, 5'd2, 5'd2, 5'd3, 5'd2, 5'd5, 5'd2, 5'd3, 5'd2, 5'd6,
        5'd3, 5'd5, 5'd2, 5'd2, 5'd2, 5'd2, 5'd7, 5'd5, 5'd3, 5'd2,
        5'd3, 5'd5, 5'd2, 5'd5, 5'd2, 5'd6, 5'd3, 5'd3, 5'd2, 5'd3,
        5'd2, 5'd2, 5'd6, 5'd5, 5'd2, 5'd5, 5'd2, 5'd2, 5'd2, 5'd19,
        5'd5, 5'd2, 5'd3, 5'd2, 5'd3, 5'd2, 5'd6, 5'd3, 5'd7, 5'd7,
        5'd6, 5'd3, 5'd5, 5'd2, 5'd6, 5'd5, 5'd3, 5'd3, 5'd2, 5'd5,
        5'd17, 5'd10, 5'd2, 5'd3, 5'd10, 5'd2, 5'd2, 5'd3, 5'd7, 5'd6,
        5'd2, 5'd2, 5'd5, 5'd2, 5'd5, 5'd3, 5'd21};

    // Request / response of the shared modular multiplier
    typedef struct packed {
        logic           start;
        logic [P_W-1:0] a;
        logic [P_W-1:0] b;
        logic [P_W-1:0] m;
    } t_mm_req;

    typedef struct packed {
        logic           done;
        logic [P_W-1:0] result;
    } t_mm_rsp;

    typedef struct packed {
        logic           valid;
        logic [K_W-1:0] address;
        logic           last;
        logic           length_error;
    } t_result;

    function automatic logic [P_W-1:0] prime_at(input logic [TBL_IDX_W-1:0] idx);
        logic [P_W-1:0] v;
        v = '0;
        if (idx < TBL_IDX_W'(TBL_SIZE)) v = PRIMES[idx];
        return v;
    endfunction

    function automatic logic [G_W-1:0] proot_at(input logic [TBL_IDX_W-1:0] idx);
        logic [G_W-1:0] v;
        v = '0;
        if (idx < TBL_IDX_W'(TBL_SIZE)) v = PROOTS[idx];
        return v;
    endfunction

    function automatic logic is_special(input logic [K_W-1:0] k);
        return (k >= SPEC_LO) && (k <= SPEC_HI);
    endfunction

    function automatic logic [ROW_W-1:0] rows_for(input logic [K_W-1:0] k);
        logic [ROW_W-1:0] r;
        if (k < R5_BELOW) r = ROWS_5;
        else if (k <= R10_MAX) r = ROWS_10;
        else if (is_special(k)) r = ROWS_10;
        else r = ROWS_20;
        return r;
    endfunction

    function automatic t_pattern pattern_for(input logic [K_W-1:0] k);
        t_pattern p;
        if (rows_for(k) == ROWS_5) p = PAT_5;
        else if (rows_for(k) == ROWS_10) p = PAT_10;
        else if ((k >= PATB_LO1 && k <= PATB_HI1) || (k >= PATB_LO2 && k <= PATB_HI2)) p = PAT_B;
        else p = PAT_A;
        return p;
    endfunction

    // Inter-row permutation: matrix row read at scan step j
    function automatic logic [ROW_W-1:0] pattern_row(input t_pattern pat,
                                                     input logic [ROW_W-1:0] j);
        logic [ROW_W-1:0] j10;
        logic [ROW_W-1:0] j5;
        logic [ROW_W-1:0] v;
        j10 = (j >= 5'd10) ? j - 5'd10 : j;
        j5  = (j10 >= 5'd5) ? j10 - 5'd5 : j10;
        v   = '0;
        unique case (pat)
            PAT_A: begin
                if (j < 5'd20) v = PAT_A_ROWS[j];
            end
            PAT_B: begin
                if (j < 5'd20) v = PAT_B_ROWS[j];
            end
            PAT_10: v = 5'd9 - j10;
            PAT_5:  v = 5'd4 - j5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/tiag_ram.sv @@
`default_nettype none
module tiag_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/core/tiag_modmul.sv @@
`default_nettype none
// Bit-serial (a*b) mod m, one bit of b per cycle, MSB first; needs a < m.
module tiag_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tiag_pkg::t_mm_req i_req,
    output tiag_pkg::t_mm_rsp o_rsp
);
    import tiag_pkg::*;

    localparam int BIT_W = $clog2(P_W);

    logic             r_busy;
    logic             r_done;
    logic [BIT_W-1:0] r_bit;
    logic [P_W-1:0]   r_a;
    logic [P_W-1:0]   r_b;
    logic [P_W-1:0]   r_m;
    logic [P_W-1:0]   r_acc;
    logic [P_W:0]     dbl;
    logic [P_W:0]     dbl_red;
    logic [P_W:0]     sum;
    logic [P_W:0]     n_acc;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        sum     = dbl_red + (r_b[r_bit] ? {1'b0, r_a} : '0);
        n_acc   = (sum >= {1'b0, r_m}) ? sum - {1'b0, r_m} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_bit  <= BIT_W'(P_W - 1);
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_m   <= i_req.m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc[P_W-1:0];
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;
endmodule
`default_nettype wire

@@ rtl/core/tiag_ctrl.sv @@
`default_nettype none
// Sequencer: parameter setup, root table build and column-wise matrix scan.
module tiag_ctrl #(
    parameter int MAX_ROWS      = 20,
    parameter int MAX_LENGTH    = 5120,
    parameter int PRIME_ENTRIES = 76,
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_restart,
    input  logic [tiag_pkg::K_W-1:0]   i_block_length,
    output logic                       o_idle,
    output tiag_pkg::t_result          o_res,
    input  logic                       i_res_take,
    output tiag_pkg::t_mm_req          o_mm_req,
    input  tiag_pkg::t_mm_rsp          i_mm_rsp,
    output logic [RIW-1:0]             o_raddr,
    output logic                       o_pwr_we,
    output logic [RIW-1:0]             o_pwr_waddr,
    output logic [tiag_pkg::P_W-1:0]   o_pwr_wdata,
    input  logic [tiag_pkg::P_W-1:0]   i_pwr_rdata,
    output logic                       o_root_we,
    output logic [RIW-1:0]             o_root_waddr,
    output logic [tiag_pkg::P_W-1:0]   o_root_wdata,
    input  logic [tiag_pkg::P_W-1:0]   i_root_rdata
);
    import tiag_pkg::*;

    localparam int LIM = (PRIME_ENTRIES > TBL_SIZE) ? TBL_SIZE :
                         ((PRIME_ENTRIES < 1) ? 1 : PRIME_ENTRIES);
    localparam logic [TBL_IDX_W-1:0] LIM_LAST = TBL_IDX_W'(LIM - 1);
    localparam logic [TBL_IDX_W-1:0] LIM_END  = TBL_IDX_W'(LIM);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_PSEARCH  = 10'b00_0000_0010,
        S_ROOT_SEL = 10'b00_0000_0100,
        S_DIV_WAIT = 10'b00_0000_1000,
        S_POW_SEL  = 10'b00_0001_0000,
        S_POW_WAIT = 10'b00_0010_0000,
        S_SCAN     = 10'b00_0100_0000,
        S_SCAN_RD  = 10'b00_1000_0000,
        S_SCAN_MUL = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [K_W-1:0]       r_k, n_k;
    logic [ROW_W-1:0]     r_rows, n_rows;
    logic [P_W-1:0]       r_prime, n_prime;
    logic [P_W-1:0]       r_cols, n_cols;
    t_pattern             r_pat, n_pat;
    logic [P_W-1:0]       r_col, n_col;
    logic [RIW-1:0]       r_row, n_row;
    logic [K_W-1:0]       r_emit, n_emit;
    logic [MAX_ROWS-1:0]  r_pwr_valid, n_pwr_valid;
    logic [TBL_IDX_W-1:0] r_pidx, n_pidx;
    logic [TBL_IDX_W-1:0] r_j, n_j;
    logic [ROW_W-1:0]     r_n, n_n;
    logic [P_W-1:0]       r_e, n_e;
    logic [P_W-1:0]       r_v, n_v;
    logic [G_W-1:0]       r_g, n_g;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [K_W-1:0]       r_idx, n_idx;
    logic                 r_hit, n_hit;
    logic [K_W-1:0]       r_res_addr, n_res_addr;
    logic                 r_res_last, n_res_last;
    logic                 r_bad, n_bad;

    logic                 cfg_bad;
    logic                 do_rewind;
    logic [P_W-1:0]       ps_prime;
    logic [CNT_W-1:0]     ps_prod;
    logic [CNT_W-1:0]     ps_rp;
    logic [CNT_W-1:0]     ps_rpm;
    logic [CNT_W-1:0]     limit;
    logic [P_W-1:0]       pw;
    logic [P_W-1:0]       col_i;
    logic [ROW_W-1:0]     prow;
    logic                 exch;
    logic [CNT_W-1:0]     idx;
    t_mm_req              mm_req;

    assign cfg_bad = (i_block_length < LEN_MIN) ||
                     (i_block_length > K_W'(MAX_LENGTH)) ||
                     (rows_for(i_block_length) > ROW_W'(MAX_ROWS));

    assign ps_prime = prime_at(r_pidx);
    assign ps_prod  = CNT_W'(r_rows) * CNT_W'(ps_prime + 9'd1);
    assign ps_rp    = CNT_W'(r_rows) * CNT_W'(ps_prime);
    assign ps_rpm   = CNT_W'(r_rows) * CNT_W'(ps_prime - 9'd1);
    assign limit    = CNT_W'(r_rows) * CNT_W'(r_cols);

    // In-row column for the position being scanned
    always_comb begin
        pw    = r_pwr_valid[r_row] ? i_pwr_rdata : 9'd1;
        prow  = pattern_row(r_pat, ROW_W'(r_row));
        exch  = (prow == r_rows - 5'd1) &&
                (CNT_W'(r_k) == CNT_W'(r_rows) * CNT_W'(r_prime + 9'd1));
        col_i = (r_cols == r_prime - 9'd1) ? pw - 9'd1 : pw;
        if (r_col == r_prime - 9'd1) col_i = '0;
        if (r_col == r_prime) col_i = r_prime;
        if (exch) begin
            if (r_col == r_prime) col_i = 9'd1;
            if (r_col == '0) col_i = r_prime;
        end
        idx = CNT_W'(prow) * CNT_W'(r_cols) + CNT_W'(col_i);
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rows      = r_rows;
        n_prime     = r_prime;
        n_cols      = r_cols;
        n_pat       = r_pat;
        n_col       = r_col;
        n_row       = r_row;
        n_emit      = r_emit;
        n_pwr_valid = r_pwr_valid;
        n_pidx      = r_pidx;
        n_j         = r_j;
        n_n         = r_n;
        n_e         = r_e;
        n_v         = r_v;
        n_g         = r_g;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_res_addr  = r_res_addr;
        n_res_last  = r_res_last;
        n_bad       = r_bad;
        do_rewind   = 1'b0;
        mm_req      = '0;
        o_pwr_we    = 1'b0;
        o_root_we   = 1'b0;
        o_root_wdata = r_v;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_bad = cfg_bad;
                    if (i_restart || r_rows == '0) begin
                        if (cfg_bad) begin
                            n_rows     = '0;
                            n_res_addr = '0;
                            n_res_last = 1'b0;
                            n_state    = S_DONE;
                        end else begin
                            n_k    = i_block_length;
                            n_rows = rows_for(i_block_length);
                            n_pat  = pattern_for(i_block_length);
                            n_j    = '0;
                            n_n    = '0;
                            n_e    = 9'd1;
                            n_pidx = '0;
                            if (is_special(i_block_length)) begin
                                n_prime = SPEC_PRIME;
                                n_cols  = SPEC_PRIME;
                                n_g     = proot_at(SPEC_PIDX);
                                n_v     = P_W'(proot_at(SPEC_PIDX));
                                n_state = S_ROOT_SEL;
                            end else begin
                                n_state = S_PSEARCH;
                            end
                        end
                    end else begin
                        do_rewind = (r_emit >= r_k);
                        n_cnt     = '0;
                        n_state   = S_SCAN;
                    end
                end
            end

            // smallest table prime with (p+1)*R >= K, else the last allowed table entry
            S_PSEARCH: begin
                if (ps_prod >= CNT_W'(r_k) || r_pidx == LIM_LAST) begin
                    n_prime = ps_prime;
                    if (ps_rp < CNT_W'(r_k)) n_cols = ps_prime + 9'd1;
                    else if (ps_rpm >= CNT_W'(r_k)) n_cols = ps_prime - 9'd1;
                    else n_cols = ps_prime;
                    n_g     = proot_at(r_pidx);
                    n_v     = P_W'(proot_at(r_pidx));
                    n_state = S_ROOT_SEL;
                end else begin
                    n_pidx = r_pidx + 1'b1;
                end
            end

            // root of row n is g^q(n) mod p; q(0) = 1, then table primes
            // that do not divide p-1
            S_ROOT_SEL: begin
                if (r_n >= r_rows) begin
                    do_rewind = 1'b1;
                    n_cnt     = '0;
                    n_state   = S_SCAN;
                end else if (r_n == '0) begin
                    o_root_we    = 1'b1;
                    o_root_wdata = r_v;
                    n_n          = r_n + 1'b1;
                end else if (r_j >= LIM_END) begin
                    o_root_we    = 1'b1;
                    o_root_wdata = P_W'(r_g);
                    n_n          = r_n + 1'b1;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.a     = 9'd1;
                    mm_req.b     = r_prime - 9'd1;
                    mm_req.m     = prime_at(r_j);
                    n_state      = S_DIV_WAIT;
                end
            end

            S_DIV_WAIT: begin
                if (i_mm_rsp.done) begin
                    if (i_mm_rsp.result == '0) begin
                        n_j     = r_j + 1'b1;
                        n_state = S_ROOT_SEL;
                    end else begin
                        n_state = S_POW_SEL;
                    end
                end
            end

            S_POW_SEL: begin
                if (r_e == prime_at(r_j)) begin
                    o_root_we    = 1'b1;
                    o_root_wdata = r_v;
                    n_n          = r_n + 1'b1;
                    n_j          = r_j + 1'b1;
                    n_state      = S_ROOT_SEL;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.a     = r_v;
                    mm_req.b     = P_W'(r_g);
                    mm_req.m     = r_prime;
                    n_state      = S_POW_WAIT;
                end
            end

            S_POW_WAIT: begin
                if (i_mm_rsp.done) begin
                    n_v     = i_mm_rsp.result;
                    n_e     = r_e + 9'd1;
                    n_state = S_POW_SEL;
                end
            end

            S_SCAN: begin
                if (r_cnt >= limit) begin
                    n_res_addr = '0;
                    n_res_last = 1'b0;
                    n_state    = S_DONE;
                end else begin
                    do_rewind = (r_col >= r_cols);
                    n_state   = S_SCAN_RD;
                end
            end

            S_SCAN_RD: begin
                n_idx        = idx[K_W-1:0];
                n_hit        = idx < CNT_W'(r_k);
                mm_req.start = 1'b1;
                mm_req.a     = pw;
                mm_req.b     = i_root_rdata;
                mm_req.m     = r_prime;
                n_state      = S_SCAN_MUL;
            end

            S_SCAN_MUL: begin
                if (i_mm_rsp.done) begin
                    o_pwr_we           = 1'b1;
                    n_pwr_valid[r_row] = 1'b1;
                    n_cnt              = r_cnt + 1'b1;
                    if (ROW_W'(r_row) + 5'd1 >= r_rows) begin
                        n_row = '0;
                        n_col = r_col + 9'd1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                    if (r_hit) begin
                        n_emit     = r_emit + 1'b1;
                        n_res_addr = r_idx;
                        n_res_last = (r_emit + 1'b1 == r_k);
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase

        if (do_rewind) begin
            n_pwr_valid = '0;
            n_col       = '0;
            n_row       = '0;
            n_emit      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_rows      <= '0;
            r_prime     <= '0;
            r_cols      <= '0;
            r_pat       <= PAT_A;
            r_col       <= '0;
            r_row       <= '0;
            r_emit      <= '0;
            r_pwr_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rows      <= n_rows;
            r_prime     <= n_prime;
            r_cols      <= n_cols;
            r_pat       <= n_pat;
            r_col       <= n_col;
            r_row       <= n_row;
            r_emit      <= n_emit;
            r_pwr_valid <= n_pwr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_j        <= n_j;
        r_n        <= n_n;
        r_e        <= n_e;
        r_v        <= n_v;
        r_g        <= n_g;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_res_addr <= n_res_addr;
        r_res_last <= n_res_last;
        r_bad      <= n_bad;
    end

    // after a rewind the read must hit row 0
    assign o_raddr      = (r_col >= r_cols) ? '0 : r_row;
    assign o_pwr_waddr  = r_row;
    assign o_pwr_wdata  = i_mm_rsp.result;
    assign o_root_waddr = r_n[RIW-1:0];
    assign o_mm_req     = mm_req;
    assign o_idle       = (r_state == S_IDLE);

    assign o_res.valid        = (r_state == S_DONE);
    assign o_res.address      = r_res_addr;
    assign o_res.last         = r_res_last;
    assign o_res.length_error = r_bad;
endmodule
`default_nettype wire

@@ rtl/core/turbo_interleaver_address_generator.sv @@
// Each result follows a scan of matrix positions (the hit plus any pruned ones); each position
//   is a RAM read of the power and root rows followed by a bit-serial modular multiply.
// After a restart, setup adds a prime search over up to 76 table entries, then a
//   divisibility test per table prime tested and a root multiply step per exponent increment.
// One transaction in work at a time; the next is taken while a result waits in the output reg.
// Reset (synchronous, active low): no parameters, block_length = 40, no result pending.
`default_nettype none
module turbo_interleaver_address_generator #(
    parameter int MAX_ROWS      = tiag_pkg::MAX_ROWS_DEF,
    parameter int MAX_LENGTH    = tiag_pkg::MAX_LENGTH_DEF,
    parameter int PRIME_ENTRIES = tiag_pkg::PRIME_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_restart,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [tiag_pkg::K_W-1:0] o_address,
    output logic                     o_last,
    output logic                     o_length_error,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [tiag_pkg::K_W-1:0] i_cfg_block_length
);
    import tiag_pkg::*;

    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [K_W-1:0] r_block_length;
    logic           r_out_valid;
    logic [K_W-1:0] r_address;
    logic           r_last;
    logic           r_length_error;

    t_result        res;
    logic           res_take;
    logic           ctrl_idle;
    t_mm_req        mm_req;
    t_mm_rsp        mm_rsp;
    logic [RIW-1:0] raddr;
    logic           pwr_we;
    logic [RIW-1:0] pwr_waddr;
    logic [P_W-1:0] pwr_wdata;
    logic [P_W-1:0] pwr_rdata;
    logic           root_we;
    logic [RIW-1:0] root_waddr;
    logic [P_W-1:0] root_wdata;
    logic [P_W-1:0] root_rdata;

    // Configuration: a plain register, always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= RESET_LEN;
        end else if (i_cfg_valid) begin
            r_block_length <= i_cfg_block_length;
        end
    end

    // Requests are taken whenever the sequencer is idle.
    assign o_in_ready = ctrl_idle;

    tiag_ctrl #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_LENGTH    (MAX_LENGTH),
        .PRIME_ENTRIES (PRIME_ENTRIES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_in_valid && ctrl_idle),
        .i_restart      (i_restart),
        .i_block_length (r_block_length),
        .o_idle         (ctrl_idle),
        .o_res          (res),
        .i_res_take     (res_take),
        .o_mm_req       (mm_req),
        .i_mm_rsp       (mm_rsp),
        .o_raddr        (raddr),
        .o_pwr_we       (pwr_we),
        .o_pwr_waddr    (pwr_waddr),
        .o_pwr_wdata    (pwr_wdata),
        .i_pwr_rdata    (pwr_rdata),
        .o_root_we      (root_we),
        .o_root_waddr   (root_waddr),
        .o_root_wdata   (root_wdata),
        .i_root_rdata   (root_rdata)
    );

    // One shared bit-serial multiplier: root build, divisibility test and power update.
    tiag_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    // Running power per row; entries not yet written since the last
    // rewind read as 1 through the sequencer's valid bits.
    tiag_ram #(
        .WIDTH (P_W),
        .DEPTH (MAX_ROWS)
    ) u_power_ram (
        .i_clk   (i_clk),
        .i_we    (pwr_we),
        .i_waddr (pwr_waddr),
        .i_wdata (pwr_wdata),
        .i_raddr (raddr),
        .o_rdata (pwr_rdata)
    );

    // Per-row multiplier root, filled during setup.
    tiag_ram #(
        .WIDTH (P_W),
        .DEPTH (MAX_ROWS)
    ) u_root_ram (
        .i_clk   (i_clk),
        .i_we    (root_we),
        .i_waddr (root_waddr),
        .i_wdata (root_wdata),
        .i_raddr (raddr),
        .o_rdata (root_rdata)
    );

    // Output register: decouples the result from the next request.
    assign res_take = res.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_address      <= res.address;
            r_last         <= res.last;
            r_length_error <= res.length_error;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_address      = r_address;
    assign o_last         = r_last;
    assign o_length_error = r_length_error;
endmodule
`default_nettype wire

@@ rtl/core/tiag_checker.sv @@
`default_nettype none
module tiag_port_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [tiag_pkg::K_W-1:0] o_address,
    input logic                     o_last,
    input logic                     o_length_error
);
    import tiag_pkg::*;

    logic [1:0] r_pend;
    logic       in_txn;
    logic       out_txn;

    assign in_txn  = i_in_valid && o_in_ready;
    assign out_txn = o_out_valid && i_out_ready;

    // transactions taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_txn) - 2'(out_txn);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_address) &&
        $stable(o_last) && $stable(o_length_error))
        else $error("stalled result changed");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_address < K_W'(MAX_LENGTH_DEF))
        else $error("address beyond block length limit");

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result without a pending transaction");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more than two transactions in flight");
endmodule

bind turbo_interleaver_address_generator tiag_port_checker u_tiag_checker (.*);
`default_nettype wire
